@@ rtl/fbc_pkg.sv @@
// Package for the frustum box cull block: request codes, register indexes,
// datapath widths and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package fbc_pkg;

  localparam int CW    = 18;  // plane coefficient
  localparam int XW    = 40;  // cross products, transformed coordinates
  localparam int AW    = 25;  // multiplier operand A
  localparam int BW    = 41;  // multiplier operand B
  localparam int PW    = AW + BW;
  localparam int ACCW  = 64;
  localparam int MAGW  = 60;  // divider magnitudes
  localparam int QW    = 31;  // quotient bits below saturation
  localparam int FCW   = 32;  // frustum corner coordinate
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam int DIV_STEPS  = QW;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_DERIVE = 2'd1,
    REQ_TEST   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA = 4'd0,
    CFG_NEAR   = 4'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_VISIBLE = 2'd0,
    VERDICT_NEAR    = 2'd1,
    VERDICT_PLANE   = 2'd2,
    VERDICT_CORNER  = 2'd3
  } verdict_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PLANES,
    OP_CROSS,
    OP_DEN,
    OP_NUM,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVSTORE,
    OP_XFORM,
    OP_ORDER,
    OP_GAP,
    OP_SQ,
    OP_NEARCHK,
    OP_DOT,
    OP_CCMP,
    OP_VERDICT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] k;
    logic [3:0] e;
    logic [1:0] s;
    logic       side;
    logic       capture;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/fbc_ifs.sv @@
// Channel interfaces of the frustum box cull block: input, result and configuration.
// Depends on fbc_pkg for the configuration widths.
`default_nettype none

interface fbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  row_index;
  logic [63:0] row_value;
  logic [63:0] xform_row_x;
  logic [63:0] xform_row_y;
  logic [63:0] xform_row_z;
  logic [47:0] box_low;
  logic [47:0] box_high;
  modport source (output valid, req_type, row_index, row_value, xform_row_x, xform_row_y,
                  xform_row_z, box_low, box_high, input ready);
  modport sink (input valid, req_type, row_index, row_value, xform_row_x, xform_row_y,
                xform_row_z, box_low, box_high, output ready);
  modport monitor (input valid, ready, req_type, row_index, row_value, xform_row_x,
                   xform_row_y, xform_row_z, box_low, box_high);
endinterface

interface fbc_out_if;
  logic       valid;
  logic       ready;
  logic       culled;
  logic [1:0] verdict;
  modport source (output valid, culled, verdict, input ready);
  modport sink (input valid, culled, verdict, output ready);
  modport monitor (input valid, ready, culled, verdict);
endinterface

interface fbc_cfg_if import fbc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
  modport monitor (input valid, ready, idx, data);
endinterface

`default_nettype wire

@@ rtl/fbc_ctrl.sv @@
// Sequencer of the frustum box cull block: steps the shared multiply-accumulate,
// divider and compare operations for load, derive and test transactions. Uses fbc_pkg.
`default_nettype none

module fbc_ctrl import fbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire status_t    status,
  output cmd_t            cmd
);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_LOAD    = 17'h00002,
    S_PLANES  = 17'h00004,
    S_CROSS   = 17'h00008,
    S_DEN     = 17'h00010,
    S_NUM     = 17'h00020,
    S_DIVI    = 17'h00040,
    S_DIVS    = 17'h00080,
    S_DIVW    = 17'h00100,
    S_XFORM   = 17'h00200,
    S_ORDER   = 17'h00400,
    S_GAP     = 17'h00800,
    S_SQ      = 17'h01000,
    S_NEARCHK = 17'h02000,
    S_DOT     = 17'h04000,
    S_CCMP    = 17'h08000,
    S_EMIT    = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [3:0] e_r, e_nxt;
  logic [1:0] s_r, s_nxt;
  logic       c_r, c_nxt;
  logic [4:0] dc_r, dc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      e_r     <= '0;
      s_r     <= '0;
      c_r     <= 1'b0;
      dc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      e_r     <= e_nxt;
      s_r     <= s_nxt;
      c_r     <= c_nxt;
      dc_r    <= dc_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    e_nxt       = e_r;
    s_nxt       = s_r;
    c_nxt       = c_r;
    dc_nxt      = dc_r;
    in_ready    = (state_r == S_IDLE);
    cmd.op      = OP_NONE;
    cmd.k       = k_r;
    cmd.e       = e_r;
    cmd.s       = s_r;
    cmd.side    = c_r;
    cmd.capture = 1'b0;
    case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        e_nxt = '0;
        s_nxt = '0;
        c_nxt = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_req_type)
            REQ_LOAD:   state_nxt = S_LOAD;
            REQ_DERIVE: state_nxt = S_PLANES;
            REQ_TEST:   state_nxt = S_XFORM;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_IDLE;
      end
      S_PLANES: begin
        cmd.op    = OP_PLANES;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (s_r == 2'd1) begin
          s_nxt = '0;
          if (e_r == 4'd8) begin
            e_nxt     = '0;
            state_nxt = S_DEN;
          end else begin
            e_nxt = e_r + 4'd1;
          end
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_DEN: begin
        cmd.op = OP_DEN;
        if (s_r == 2'd2) begin
          s_nxt     = '0;
          e_nxt     = '0;
          state_nxt = S_NUM;
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_NUM: begin
        cmd.op = OP_NUM;
        if (s_r == 2'd2) begin
          s_nxt     = '0;
          state_nxt = S_DIVI;
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIVINIT;
        dc_nxt    = '0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = OP_DIVSTEP;
        if (dc_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_DIVW;
        end else begin
          dc_nxt = dc_r + 5'd1;
        end
      end
      S_DIVW: begin
        cmd.op = OP_DIVSTORE;
        if (e_r == 4'd2) begin
          e_nxt = '0;
          if (k_r == 3'd7) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = S_CROSS;
          end
        end else begin
          e_nxt     = e_r + 4'd1;
          state_nxt = S_NUM;
        end
      end
      S_XFORM: begin
        cmd.op = OP_XFORM;
        if (s_r == 2'd2) begin
          s_nxt = '0;
          if (c_r) begin
            c_nxt     = 1'b0;
            state_nxt = S_ORDER;
          end else begin
            c_nxt = 1'b1;
          end
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_ORDER: begin
        cmd.op = OP_ORDER;
        if (e_r == 4'd2) begin
          e_nxt     = '0;
          state_nxt = S_GAP;
        end else begin
          e_nxt     = e_r + 4'd1;
          state_nxt = S_XFORM;
        end
      end
      S_GAP: begin
        cmd.op = OP_GAP;
        if (e_r == 4'd2) begin
          e_nxt     = '0;
          s_nxt     = '0;
          state_nxt = S_SQ;
        end else begin
          e_nxt = e_r + 4'd1;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (s_r == 2'd3) begin
          s_nxt     = '0;
          state_nxt = S_NEARCHK;
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_NEARCHK: begin
        cmd.op    = OP_NEARCHK;
        k_nxt     = '0;
        e_nxt     = '0;
        s_nxt     = '0;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (s_r == 2'd2) begin
          s_nxt = '0;
          if (k_r == 3'd7) begin
            k_nxt = '0;
            if (e_r == 4'd5) begin
              e_nxt     = '0;
              state_nxt = S_CCMP;
            end else begin
              e_nxt = e_r + 4'd1;
            end
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end else begin
          s_nxt = s_r + 2'd1;
        end
      end
      S_CCMP: begin
        cmd.op = OP_CCMP;
        if (k_r == 3'd7) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_VERDICT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/fbc_datapath.sv @@
// Datapath of the frustum box cull block: matrix, plane and corner storage, one shared
// multiply-accumulate, a restoring divider, compare flags and the result register.
// Uses fbc_pkg; driven by fbc_ctrl commands.
`default_nettype none

module fbc_datapath import fbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  input  wire logic [1:0]            in_row_index,
  input  wire logic [63:0]           in_row_value,
  input  wire logic [63:0]           in_xform_row_x,
  input  wire logic [63:0]           in_xform_row_y,
  input  wire logic [63:0]           in_xform_row_z,
  input  wire logic [47:0]           in_box_low,
  input  wire logic [47:0]           in_box_high,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_culled,
  output logic [1:0]                 out_verdict
);

  function automatic logic signed [15:0] lane16(input logic [63:0] v, input logic [1:0] k);
    return v[{k, 4'b0000} +: 16];
  endfunction

  logic [1:0]  rowidx_r;
  logic [63:0] rowval_r;
  logic [63:0] xr_r [3];
  logic [47:0] blo_r, bhi_r;

  logic [47:0] cam_r;
  logic [15:0] nrad_r;

  logic signed [15:0]    vm_r [4][4];
  logic signed [CW-1:0]  pl_r [6][4];
  logic signed [FCW-1:0] fc_r [8][3];

  logic signed [XW-1:0]   cr_r [9];
  logic signed [ACCW-1:0] acc_r, den_r, num_r;
  logic signed [XW-1:0]   xlo_r [3];
  logic signed [XW-1:0]   xhi_r [3];
  logic signed [XW-1:0]   mn_r [3];
  logic signed [XW-1:0]   mx_r [3];
  logic signed [BW-1:0]   d_r [3];
  logic                   far_r, near_r;
  logic [5:0]             allneg_r;
  logic [2:0]             above_r, below_r;

  logic [MAGW-1:0] rem_r, dmag_r;
  logic [QW-1:0]   nlo_r, q_r;
  logic            neg_r, sat_r, zero_r;

  logic            out_valid_r, out_culled_r;
  logic [1:0]      out_verdict_r;

  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic                   mul_neg;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] init, base, term, acc_nxt;
  logic [2:0]             pa, pb, pc, px, py, ps;
  logic [1:0]             ci, i1, i2, sm1;
  logic [3:0]             nidx;
  logic [1:0]             ax;

  logic signed [XW-1:0] cam_c, cam_cl;
  logic signed [BW-1:0] gap;
  logic                 gap_far;

  logic signed [ACCW-1:0] nabs, dabs;
  logic [MAGW-1:0]        nmag, dmag;
  logic                   sat_c;
  logic [MAGW:0]          dv_t, dv_sub;
  logic                   dv_ge;
  logic signed [FCW-1:0]  div_res;
  logic                   plane_cull, corner_cull;
  verdict_t               verdict_c;

  assign prod = mul_a * mul_b;

  always_comb begin
    pa = {2'b00, cmd.k[1]};
    pb = 3'd2 + {2'b00, cmd.k[0]};
    pc = 3'd4 + {2'b00, cmd.k[2]};
    case (cmd.e)
      4'd0, 4'd1, 4'd2: begin
        px = pb;
        py = pc;
      end
      4'd3, 4'd4, 4'd5: begin
        px = pc;
        py = pa;
      end
      default: begin
        px = pa;
        py = pb;
      end
    endcase
    case (cmd.e)
      4'd0, 4'd3, 4'd6: ci = 2'd0;
      4'd1, 4'd4, 4'd7: ci = 2'd1;
      default:          ci = 2'd2;
    endcase
    i1 = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
    i2 = (ci == 2'd0) ? 2'd2 : ci - 2'd1;
    case (cmd.s)
      2'd0:    ps = pa;
      2'd1:    ps = pb;
      default: ps = pc;
    endcase
    case (cmd.s)
      2'd0:    nidx = {2'b00, cmd.e[1:0]};
      2'd1:    nidx = {2'b00, cmd.e[1:0]} + 4'd3;
      default: nidx = {2'b00, cmd.e[1:0]} + 4'd6;
    endcase
    sm1 = cmd.s - 2'd1;
    ax  = (cmd.s == 2'd3) ? 2'd2 : cmd.s;

    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    init    = '0;
    case (cmd.op)
      OP_CROSS: begin
        if (!cmd.s[0]) begin
          mul_a = AW'(pl_r[px][i1]);
          mul_b = BW'(pl_r[py][i2]);
        end else begin
          mul_a   = AW'(pl_r[px][i2]);
          mul_b   = BW'(pl_r[py][i1]);
          mul_neg = 1'b1;
        end
      end
      OP_DEN: begin
        mul_a = AW'(pl_r[pa][cmd.s]);
        mul_b = BW'(cr_r[{2'b00, cmd.s}]);
      end
      OP_NUM: begin
        mul_a = AW'(pl_r[ps][3]);
        mul_b = BW'(cr_r[nidx]);
      end
      OP_XFORM: begin
        mul_a = AW'(lane16(xr_r[cmd.e[1:0]], cmd.s));
        mul_b = BW'(lane16(cmd.side ? {16'h0000, bhi_r} : {16'h0000, blo_r}, cmd.s));
        init  = ACCW'(lane16(xr_r[cmd.e[1:0]], 2'd3)) <<< 8;
      end
      OP_SQ: begin
        if (cmd.s == 2'd0) begin
          mul_a   = AW'({1'b0, nrad_r, 8'h00});
          mul_b   = BW'({1'b0, nrad_r, 8'h00});
          mul_neg = 1'b1;
        end else begin
          mul_a = d_r[sm1][AW-1:0];
          mul_b = d_r[sm1];
        end
      end
      OP_DOT: begin
        mul_a = AW'(pl_r[cmd.e[2:0]][cmd.s]);
        mul_b = BW'(cmd.k[ax] ? mx_r[ax] : mn_r[ax]);
        init  = ACCW'(pl_r[cmd.e[2:0]][3]) <<< 16;
      end
      default: begin
        mul_a = '0;
      end
    endcase
    base    = (cmd.s == 2'd0) ? init : acc_r;
    term    = mul_neg ? -prod[ACCW-1:0] : prod[ACCW-1:0];
    acc_nxt = base + term;
  end

  always_comb begin
    cam_c   = XW'(lane16({16'h0000, cam_r}, cmd.e[1:0])) <<< 8;
    cam_cl  = (cam_c < mn_r[cmd.e[1:0]]) ? mn_r[cmd.e[1:0]] : cam_c;
    if (cam_cl > mx_r[cmd.e[1:0]]) begin
      cam_cl = mx_r[cmd.e[1:0]];
    end
    gap     = BW'(cam_c) - BW'(cam_cl);
    gap_far = (gap <= -(BW'(1) <<< 24)) || (gap >= (BW'(1) <<< 24));
  end

  always_comb begin
    nabs   = num_r[ACCW-1] ? -num_r : num_r;
    dabs   = den_r[ACCW-1] ? -den_r : den_r;
    nmag   = nabs[MAGW-1:0];
    dmag   = dabs[MAGW-1:0];
    sat_c  = {15'd0, nmag} >= {dmag, 15'd0};
    dv_t   = {rem_r, nlo_r[QW-1]};
    dv_sub = dv_t - {1'b0, dmag_r};
    dv_ge  = dv_t >= {1'b0, dmag_r};
    if (zero_r) begin
      div_res = '0;
    end else if (sat_r) begin
      div_res = neg_r ? {1'b1, {(FCW-1){1'b0}}} : {1'b0, {(FCW-1){1'b1}}};
    end else if (neg_r) begin
      div_res = -$signed({1'b0, q_r});
    end else begin
      div_res = $signed({1'b0, q_r});
    end
  end

  always_comb begin
    plane_cull  = |allneg_r;
    corner_cull = (|above_r) || (|below_r);
    if (near_r) begin
      verdict_c = VERDICT_NEAR;
    end else if (plane_cull) begin
      verdict_c = VERDICT_PLANE;
    end else if (corner_cull) begin
      verdict_c = VERDICT_CORNER;
    end else begin
      verdict_c = VERDICT_VISIBLE;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rowidx_r <= in_row_index;
      rowval_r <= in_row_value;
      xr_r[0]  <= in_xform_row_x;
      xr_r[1]  <= in_xform_row_y;
      xr_r[2]  <= in_xform_row_z;
      blo_r    <= in_box_low;
      bhi_r    <= in_box_high;
    end
    case (cmd.op)
      OP_CROSS, OP_DEN, OP_NUM, OP_XFORM, OP_SQ, OP_DOT: acc_r <= acc_nxt;
      default: acc_r <= acc_r;
    endcase
    if (cmd.op == OP_CROSS && cmd.s == 2'd1) begin
      cr_r[cmd.e] <= acc_nxt[XW-1:0];
    end
    if (cmd.op == OP_DEN && cmd.s == 2'd2) begin
      den_r <= acc_nxt;
    end
    if (cmd.op == OP_NUM && cmd.s == 2'd2) begin
      num_r <= acc_nxt;
    end
    if (cmd.op == OP_XFORM && cmd.s == 2'd2) begin
      if (cmd.side) begin
        xhi_r[cmd.e[1:0]] <= acc_nxt[XW-1:0];
      end else begin
        xlo_r[cmd.e[1:0]] <= acc_nxt[XW-1:0];
      end
    end
    if (cmd.op == OP_ORDER) begin
      if (xlo_r[cmd.e[1:0]] < xhi_r[cmd.e[1:0]]) begin
        mn_r[cmd.e[1:0]] <= xlo_r[cmd.e[1:0]];
        mx_r[cmd.e[1:0]] <= xhi_r[cmd.e[1:0]];
      end else begin
        mn_r[cmd.e[1:0]] <= xhi_r[cmd.e[1:0]];
        mx_r[cmd.e[1:0]] <= xlo_r[cmd.e[1:0]];
      end
    end
    if (cmd.op == OP_GAP) begin
      d_r[cmd.e[1:0]] <= gap;
      far_r           <= ((cmd.e == 4'd0) ? 1'b0 : far_r) | gap_far;
    end
    if (cmd.op == OP_NEARCHK) begin
      near_r <= !far_r && acc_r[ACCW-1];
    end
    if (cmd.op == OP_DOT && cmd.s == 2'd2) begin
      allneg_r[cmd.e[2:0]] <= ((cmd.k == 3'd0) | allneg_r[cmd.e[2:0]]) & acc_nxt[ACCW-1];
    end
    if (cmd.op == OP_CCMP) begin
      for (int i = 0; i < 3; i++) begin
        above_r[i] <= ((cmd.k == 3'd0) | above_r[i]) & (fc_r[cmd.k][i] > mx_r[i]);
        below_r[i] <= ((cmd.k == 3'd0) | below_r[i]) & (fc_r[cmd.k][i] < mn_r[i]);
      end
    end
    if (cmd.op == OP_DIVINIT) begin
      dmag_r <= dmag;
      rem_r  <= nmag >> 15;
      nlo_r  <= {nmag[14:0], 16'h0000};
      q_r    <= '0;
      neg_r  <= (num_r[ACCW-1] == den_r[ACCW-1]);
      sat_r  <= sat_c;
      zero_r <= (num_r == '0);
    end
    if (cmd.op == OP_DIVSTEP) begin
      rem_r <= dv_ge ? dv_sub[MAGW-1:0] : dv_t[MAGW-1:0];
      nlo_r <= {nlo_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], dv_ge};
    end
    if (cmd.op == OP_VERDICT) begin
      out_verdict_r <= verdict_c;
      out_culled_r  <= !near_r && (plane_cull || corner_cull);
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r       <= '0;
      nrad_r      <= 16'd256;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          vm_r[r][j] <= '0;
        end
      end
      for (int p = 0; p < 6; p++) begin
        for (int j = 0; j < 4; j++) begin
          pl_r[p][j] <= '0;
        end
      end
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 3; i++) begin
          fc_r[k][i] <= '0;
        end
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_idx)
          CFG_CAMERA: cam_r  <= cfg_data;
          CFG_NEAR:   nrad_r <= cfg_data[15:0];
          default:    cam_r  <= cam_r;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        for (int j = 0; j < 4; j++) begin
          vm_r[rowidx_r][j] <= lane16(rowval_r, 2'(j));
        end
      end
      if (cmd.op == OP_PLANES) begin
        for (int p = 0; p < 6; p++) begin
          for (int j = 0; j < 4; j++) begin
            if (p % 2 == 1) begin
              pl_r[p][j] <= CW'(vm_r[3][j]) - CW'(vm_r[p / 2][j]);
            end else begin
              pl_r[p][j] <= CW'(vm_r[3][j]) + CW'(vm_r[p / 2][j]);
            end
          end
        end
      end
      if (cmd.op == OP_DIVSTORE) begin
        fc_r[cmd.k][cmd.e[1:0]] <= div_res;
      end
      if (cmd.op == OP_VERDICT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_culled      = out_culled_r;
  assign out_verdict     = out_verdict_r;

endmodule

`default_nettype wire

@@ rtl/frustum_box_cull.sv @@
// Top level of the frustum box cull block: joins the sequencer and the datapath to
// the channel interfaces. Depends on fbc_pkg, fbc_ifs, fbc_ctrl and fbc_datapath.
//
//   channel   dir  payload                                       transaction
//   in_chan   in   req_type,row_index,row_value,xform_*,box_*    valid & ready
//   out_chan  out  culled, verdict                               valid & ready
//   cfg_chan  in   idx, data                                     valid & ready (always ready)
//
// One transaction at a time on one multiply-accumulate unit and a one-bit-per-cycle divider.
// Load: accept, then write the matrix row. Derive: accept, plane setup, then
// 8 corners x (18 cross multiplies, 3 den multiplies, 3 x (3 num multiplies and a divide)).
// Test: dominated by 48 plane dot products of 3 multiplies each.
// Reset (rst_n low, synchronous) clears matrix, planes, corners, camera, sequencer, out_valid.
// A finished verdict sits in the output register; a stalled out_chan holds only the emit step.
`default_nettype none

module frustum_box_cull import fbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fbc_in_if.sink    in_chan,
  fbc_out_if.source out_chan,
  fbc_cfg_if.sink   cfg_chan
);

  cmd_t    cmd;
  status_t status;

  assign cfg_chan.ready = 1'b1;

  fbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_req_type (in_chan.req_type),
    .status      (status),
    .cmd         (cmd)
  );

  fbc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_row_index   (in_chan.row_index),
    .in_row_value   (in_chan.row_value),
    .in_xform_row_x (in_chan.xform_row_x),
    .in_xform_row_y (in_chan.xform_row_y),
    .in_xform_row_z (in_chan.xform_row_z),
    .in_box_low     (in_chan.box_low),
    .in_box_high    (in_chan.box_high),
    .cfg_valid      (cfg_chan.valid),
    .cfg_idx        (cfg_chan.idx),
    .cfg_data       (cfg_chan.data),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_culled     (out_chan.culled),
    .out_verdict    (out_chan.verdict)
  );

endmodule

`default_nettype wire
